>>> sv/ddiff_pkg.sv
`default_nettype none

package ddiff_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 6;
  localparam int HOUR_W  = 6;
  localparam int MIN_W   = 7;
  localparam int SEC_W   = 7;
  localparam int COUNT_W = 23;
  localparam int STAT_W  = 2;
  localparam int QUO_W   = 8;   // 16383 / 100 fits in 8 bits

  // Reciprocal of 100 as 5243 / 2^19; exact for every 14-bit dividend.
  localparam int RECIP100   = 5243;
  localparam int RECIP_SH   = 19;
  localparam int PROD_W     = YEAR_W + 13;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DATE_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TIME_ERR = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 6'd23;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 7'd59;
  localparam logic [SEC_W-1:0]   SEC_MAX   = 7'd59;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [HOUR_W-1:0]  first_hour;
    logic [MIN_W-1:0]   first_minute;
    logic [SEC_W-1:0]   first_second;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic [HOUR_W-1:0]  second_hour;
    logic [MIN_W-1:0]   second_minute;
    logic [SEC_W-1:0]   second_sec;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  first_status;
    logic [STAT_W-1:0]  second_status;
    logic [COUNT_W-1:0] day_count;
  } rsp_t;

  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [PROD_W-1:0] prod;
    prod = {13'd0, v} * PROD_W'(RECIP100);
    return prod[RECIP_SH +: QUO_W];
  endfunction

  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [QUO_W-1:0]  q;
    logic [YEAR_W-1:0] hundreds;
    q        = div100(y);
    hundreds = YEAR_W'({q, 6'd0}) + YEAR_W'({q, 5'd0}) + YEAR_W'({q, 2'd0});
    return (y[1:0] == 2'd0) && ((y != hundreds) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 6'd30;
      MONTH_FEB:                                 len = leap ? 6'd29 : 6'd28;
      default:                                   len = 6'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [STAT_W-1:0] stamp_status(
      input logic [YEAR_W-1:0]  y,
      input logic [MONTH_W-1:0] m,
      input logic [DAY_W-1:0]   d,
      input logic [HOUR_W-1:0]  h,
      input logic [MIN_W-1:0]   mi,
      input logic [SEC_W-1:0]   s,
      input logic               leap);
    logic             date_ok;
    logic             time_ok;
    logic [STAT_W-1:0] st;
    date_ok = (y != '0) && (m inside {[4'd1:MONTH_DEC]}) && (d != '0) &&
              (d <= month_len(m, leap));
    time_ok = (h <= HOUR_MAX) && (mi <= MIN_MAX) && (s <= SEC_MAX);
    st = STAT_OK;
    if (!date_ok) st = st | STAT_DATE_ERR;
    if (!time_ok) st = st | STAT_TIME_ERR;
    return st;
  endfunction

  // Day number with 1-01-01 as day 1.
  function automatic logic [COUNT_W-1:0] day_number(input logic [YEAR_W-1:0]  y,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [DAY_W-1:0]   d,
                                                    input logic               leap);
    logic [YEAR_W-1:0]  p;
    logic [QUO_W-1:0]   q;
    logic [COUNT_W-1:0] n;
    p = y - YEAR_W'(1);
    q = div100(p);
    n = {{(COUNT_W-YEAR_W){1'b0}}, p} * COUNT_W'(365);
    n = n + COUNT_W'(p >> 2) - COUNT_W'(q) + COUNT_W'(q >> 2);
    n = n + COUNT_W'(days_before(m)) + COUNT_W'(d);
    if ((m > MONTH_FEB) && leap) n = n + COUNT_W'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/date_validate_and_day_difference.sv
`default_nettype none

// Gregorian date check and day difference for a pair of date-time stamps.
//
// Request channel (req_valid / req_ready / req): one pair of stamps, each
// year, month, day, hour, minute, second. Response channel (rsp_valid /
// rsp_ready / rsp): a status per stamp (bit 0 date error, bit 1 time error)
// and the absolute number of days between the two dates, forced to 0 when
// either stamp is bad. Time of day never enters the count.
//
// An accepted request lands in the request register and moves on to the
// response register when that register is free or drains now. The block
// takes one request per cycle while the receiver does not stall; the whole
// check and the day-number difference sit in one combinational pass
// between the two registers.
//
// Reset (rst, synchronous) empties both registers; no response is pending.
// When the receiver stalls, the response register holds, the request
// register takes the next request and then holds it, and req_ready drops
// only once both registers are full.
module date_validate_and_day_difference (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_ready,
  input  wire ddiff_pkg::req_t req,
  output logic              rsp_valid,
  input  wire               rsp_ready,
  output ddiff_pkg::rsp_t   rsp
);
  import ddiff_pkg::*;

  // Request register.
  logic  hold_valid;
  req_t  hold;
  logic  advance;

  // Combinational pass.
  logic               leap1, leap2;
  logic [STAT_W-1:0]  st1, st2;
  logic [COUNT_W-1:0] dn1, dn2;
  rsp_t               rsp_next;

  // Advance the held request when the response register is free or drains now.
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  // Validate both stamps and take the difference of their day numbers.
  always_comb begin
    leap1 = leap_year(hold.first_year);
    leap2 = leap_year(hold.second_year);
    st1 = stamp_status(hold.first_year, hold.first_month, hold.first_day,
                       hold.first_hour, hold.first_minute, hold.first_second, leap1);
    st2 = stamp_status(hold.second_year, hold.second_month, hold.second_day,
                       hold.second_hour, hold.second_minute, hold.second_sec, leap2);
    dn1 = day_number(hold.first_year, hold.first_month, hold.first_day, leap1);
    dn2 = day_number(hold.second_year, hold.second_month, hold.second_day, leap2);
    rsp_next.first_status  = st1;
    rsp_next.second_status = st2;
    if ((st1 != STAT_OK) || (st2 != STAT_OK)) begin
      rsp_next.day_count = '0;
    end else if (dn1 > dn2) begin
      rsp_next.day_count = dn1 - dn2;
    end else begin
      rsp_next.day_count = dn2 - dn1;
    end
  end

  // Response register: load when the request moves on, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // A nonzero count only comes with two valid stamps.
  a_count_needs_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.day_count != '0) |->
      (rsp.first_status == STAT_OK) && (rsp.second_status == STAT_OK))
    else $error("day count given for an invalid stamp");

  // An accepted request always lands in the request register.
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> hold_valid)
    else $error("accepted request lost");

  // Back-pressure reaches the request side only when both registers are full.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> hold_valid && rsp_valid && !rsp_ready)
    else $error("request side stalled without cause");

  // After reset neither the request nor the response register holds an item.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid && !hold_valid)
    else $error("pending item after reset");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_date_validate_and_day_difference.sv
`default_nettype none

module tb_date_validate_and_day_difference;
  import ddiff_pkg::*;

  // One date-time stamp, as the request carries it twice.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

  // A request waiting for the driver; a set hold flag makes the driver
  // wait until every response in flight has come back before sending it.
  typedef struct {
    req_t pair;
    bit   hold;
  } pending_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  pending_t pending_pairs[$];
  rsp_t     expected_diffs[$];

  // The accepted and received counters move with nonblocking updates so both
  // clocked blocks see the same values at an edge.
  int accepted_cnt   = 0;
  int received_cnt   = 0;
  int bad_results    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  date_validate_and_day_difference i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Length of month m in year y; 0 for a month that does not exist.
  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic logic [STAT_W-1:0] judge_stamp(stamp_t s);
    logic [STAT_W-1:0] st;
    bit                date_ok;
    st = STAT_OK;
    // Check year and month first; look up the day only for a real month.
    date_ok = (s.year >= 1) && (s.month >= 1) && (s.month <= 12);
    if (date_ok)
      date_ok = (s.day >= 1) && (s.day <= month_days(32'(s.year), 32'(s.month)));
    if (!date_ok)
      st = st | STAT_DATE_ERR;
    if ((s.hour > HOUR_MAX) || (s.minute > MIN_MAX) || (s.second > SEC_MAX))
      st = st | STAT_TIME_ERR;
    return st;
  endfunction

  // Days since the start of the calendar, counting 1-01-01 as day 1.
  function automatic int unsigned ordinal_day(stamp_t s);
    int unsigned p;
    int unsigned n;
    p = 32'(s.year) - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned k = 1; k < s.month; k++)
      n += month_days(32'(s.year), k);
    return n + 32'(s.day);
  endfunction

  function automatic rsp_t predict_diff(req_t r);
    stamp_t      a;
    stamp_t      b;
    rsp_t        res;
    int unsigned da;
    int unsigned db;
    a = '{r.first_year, r.first_month, r.first_day,
          r.first_hour, r.first_minute, r.first_second};
    b = '{r.second_year, r.second_month, r.second_day,
          r.second_hour, r.second_minute, r.second_sec};
    res.first_status  = judge_stamp(a);
    res.second_status = judge_stamp(b);
    res.day_count     = '0;
    // Count days only when both stamps pass; time of day never counts.
    if ((res.first_status == STAT_OK) && (res.second_status == STAT_OK)) begin
      da = ordinal_day(a);
      db = ordinal_day(b);
      res.day_count = COUNT_W'((da > db) ? (da - db) : (db - da));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  function automatic stamp_t mk(int unsigned y, int unsigned m, int unsigned d,
                                int unsigned h, int unsigned mi, int unsigned s);
    return '{YEAR_W'(y), MONTH_W'(m), DAY_W'(d), HOUR_W'(h), MIN_W'(mi), SEC_W'(s)};
  endfunction

  // Well-formed stamp; bias the year toward century and leap boundaries and the range ends.
  function automatic stamp_t rand_good();
    int unsigned y;
    int unsigned m;
    case ($urandom_range(4, 0))
      0:       y = $urandom_range(163, 1) * 100;
      1:       y = $urandom_range(4095, 1) * 4;
      2:       y = $urandom_range(1) ? 1 : 16383;
      default: y = $urandom_range(16383, 1);
    endcase
    m = $urandom_range(12, 1);
    return mk(y, m, $urandom_range(month_days(y, m), 1),
              $urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(59, 0));
  endfunction

  function automatic stamp_t break_date(stamp_t s);
    case ($urandom_range(3, 0))
      0: s.year  = '0;
      1: s.month = $urandom_range(1) ? MONTH_W'(0) : MONTH_W'($urandom_range(15, 13));
      2: s.day   = '0;
      default: s.day = DAY_W'($urandom_range(63,
                                month_days(32'(s.year), 32'(s.month)) + 1));
    endcase
    return s;
  endfunction

  function automatic stamp_t break_time(stamp_t s);
    case ($urandom_range(2, 0))
      0: s.hour   = HOUR_W'($urandom_range(63, 24));
      1: s.minute = MIN_W'($urandom_range(127, 60));
      default: s.second = SEC_W'($urandom_range(127, 60));
    endcase
    return s;
  endfunction

  function automatic stamp_t rand_noise();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return stamp_t'(raw[$bits(stamp_t)-1:0]);
  endfunction

  task automatic queue_pair(stamp_t a, stamp_t b, bit hold);
    pending_t p;
    p.pair = '{a.year, a.month, a.day, a.hour, a.minute, a.second,
               b.year, b.month, b.day, b.hour, b.minute, b.second};
    p.hold = hold;
    pending_pairs.push_back(p);
  endtask

  // Mostly well-formed pairs with random content, the rest broken or noise.
  task automatic queue_random_pair(bit hold);
    stamp_t      a;
    stamp_t      b;
    stamp_t      t;
    int unsigned pick;
    a    = rand_good();
    b    = rand_good();
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      // same date, different times
      b.year  = a.year;
      b.month = a.month;
      b.day   = a.day;
    end else if (pick < 22) begin
      b.year = a.year;
      b.day  = DAY_W'($urandom_range(month_days(32'(b.year), 32'(b.month)), 1));
    end else if (pick < 65) begin
      // independent well-formed stamps
    end else if (pick < 75) begin
      b = break_date(b);
    end else if (pick < 85) begin
      b = break_time(b);
    end else if (pick < 92) begin
      b = break_time(break_date(b));
    end else begin
      a = rand_noise();
      b = rand_noise();
    end
    if ($urandom_range(1)) begin
      t = a;
      a = b;
      b = t;
    end
    queue_pair(a, b, hold);
  endtask

  task automatic queue_directed();
    // widest span, both ways round
    queue_pair(mk(1, 1, 1, 0, 0, 0), mk(16383, 12, 31, 23, 59, 59), 1'b0);
    queue_pair(mk(16383, 12, 31, 23, 59, 59), mk(1, 1, 1, 0, 0, 0), 1'b0);
    // leap rules, at the century and elsewhere
    queue_pair(mk(2000, 2, 29, 12, 0, 0), mk(1900, 2, 28, 0, 0, 0), 1'b0);
    queue_pair(mk(1900, 2, 29, 0, 0, 0), mk(1901, 1, 1, 0, 0, 0), 1'b0);
    queue_pair(mk(2024, 2, 29, 1, 2, 3), mk(2023, 2, 29, 1, 2, 3), 1'b0);
    queue_pair(mk(2000, 3, 1, 0, 0, 0), mk(2000, 2, 28, 0, 0, 0), 1'b0);
    queue_pair(mk(2100, 3, 1, 0, 0, 0), mk(2100, 2, 28, 0, 0, 0), 1'b0);
    queue_pair(mk(400, 12, 31, 0, 0, 0), mk(401, 1, 1, 0, 0, 0), 1'b0);
    queue_pair(mk(1999, 12, 31, 23, 59, 59), mk(2000, 1, 1, 0, 0, 0), 1'b0);
    // bad year or month, day not looked up
    queue_pair(mk(0, 6, 15, 0, 0, 0), mk(2020, 6, 15, 0, 0, 0), 1'b0);
    queue_pair(mk(2020, 0, 15, 0, 0, 0), mk(2020, 6, 15, 0, 0, 0), 1'b0);
    queue_pair(mk(2020, 6, 15, 0, 0, 0), mk(2020, 13, 1, 0, 0, 0), 1'b0);
    queue_pair(mk(2020, 15, 63, 0, 0, 0), mk(2020, 6, 15, 0, 0, 0), 1'b0);
    // bad day
    queue_pair(mk(2020, 1, 0, 0, 0, 0), mk(2020, 1, 31, 0, 0, 0), 1'b0);
    queue_pair(mk(2020, 1, 32, 0, 0, 0), mk(2020, 4, 31, 0, 0, 0), 1'b0);
    queue_pair(mk(2020, 5, 63, 0, 0, 0), mk(2020, 5, 1, 0, 0, 0), 1'b0);
    // bad time fields
    queue_pair(mk(2020, 5, 1, 24, 0, 0), mk(2020, 5, 1, 23, 59, 59), 1'b0);
    queue_pair(mk(2020, 5, 1, 0, 60, 0), mk(2020, 5, 1, 0, 0, 60), 1'b0);
    queue_pair(mk(2020, 5, 1, 63, 127, 127), mk(2020, 5, 2, 0, 0, 0), 1'b0);
    // date and time both bad
    queue_pair(mk(0, 1, 1, 24, 0, 0), mk(2020, 13, 1, 0, 0, 127), 1'b0);
    // same date, only the times differ
    queue_pair(mk(2021, 6, 15, 0, 0, 0), mk(2021, 6, 15, 23, 59, 59), 1'b0);
    // all fields at zero against all fields at maximum
    queue_pair(mk(0, 0, 0, 0, 0, 0), mk(16383, 15, 63, 63, 127, 127), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------
  // Record the expected response at each accepted request, then refill the
  // slot when it is free. A held request waits until nothing is in flight.
  always @(posedge clk) begin : drive_requests
    pending_t nxt;
    bit       fire;
    bit       taken;
    int       in_flight;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      taken = req_valid && req_ready;
      if (taken) begin
        expected_diffs.push_back(predict_diff(req));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!req_valid || req_ready) begin
        in_flight = accepted_cnt + (taken ? 1 : 0) - received_cnt;
        fire = (pending_pairs.size() > 0) && ($urandom_range(99, 0) >= send_idle_pct);
        if (fire && pending_pairs[0].hold && (in_flight != 0))
          fire = 1'b0;
        if (fire) begin
          nxt = pending_pairs.pop_front();
          req       <= nxt.pair;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Response monitor
  // ---------------------------------------------------------------------

  task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  // Stall at random, and compare each accepted response with the oldest
  // expectation, field by field.
  always @(posedge clk) begin : check_responses
    rsp_t want;
    rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    if (!rst && rsp_valid && rsp_ready) begin
      received_cnt <= received_cnt + 1;
      if (expected_diffs.size() == 0) begin
        flag_field("unexpected response, day_count", 32'd0, 32'(rsp.day_count));
      end else begin
        want = expected_diffs.pop_front();
        if (rsp.first_status !== want.first_status)
          flag_field("first_status", 32'(want.first_status), 32'(rsp.first_status));
        if (rsp.second_status !== want.second_status)
          flag_field("second_status", 32'(want.second_status), 32'(rsp.second_status));
        if (rsp.day_count !== want.day_count)
          flag_field("day_count", 32'(want.day_count), 32'(rsp.day_count));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------

  // Hold until every queued request has gone out and come back.
  task automatic wait_drain();
    while ((pending_pairs.size() != 0) || req_valid || (expected_diffs.size() != 0))
      @(negedge clk);
  endtask

  initial begin : run_phases
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly, receiver stalls often.
    send_idle_pct  = 17;
    recv_stall_pct = 68;
    queue_directed();
    for (int i = 0; i < 425; i++)
      queue_random_pair(i % 200 == 100);
    wait_drain();

    // Swap: sender idles often, receiver stalls lightly.
    send_idle_pct  = 68;
    recv_stall_pct = 17;
    for (int i = 0; i < 425; i++)
      queue_random_pair(i % 200 == 100);
    wait_drain();

    // Full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 425; i++)
      queue_random_pair(i % 200 == 100);
    wait_drain();

    // Give a stray response time to show up.
    repeat (8) @(negedge clk);
    if (bad_results == 0)
      $display("** date_validate_and_day_difference: PASSED **");
    else
      $display("** date_validate_and_day_difference: FAILED **");
    $finish;
  end

  // Generous bound: far beyond the slowest correct run of about 1300
  // requests under heavy stalls.
  initial begin : watchdog
    #2000000;
    $display("** date_validate_and_day_difference: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
